>>> rtl/frss_pkg.sv
// Shared types and constants of the fixed record slot store.
package frss_pkg;

	localparam int SLOT_COUNT_DEF   = 256;
	localparam int RECORD_WIDTH_DEF = 64;

	localparam int REQ_W   = 2;
	localparam int POS_W   = 8;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 9;
	localparam int STAT_W  = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_READ   = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_COUNT  = 2'd3
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_BADPOS  = 2'd1,
		ST_DELETED = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		MODE_MOVE_LAST = 1'b0,
		MODE_FREE_LIST = 1'b1
	} delete_mode_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic commit;
	} ctl_cmd_t;

endpackage

>>> rtl/frss_if.sv
// Request and response channel interfaces of the fixed record slot store.
interface frss_req_if;
	logic                       valid;
	logic                       ready;
	logic [frss_pkg::REQ_W-1:0]  req_type;
	logic [frss_pkg::POS_W-1:0]  slot_index;
	logic [frss_pkg::DATA_W-1:0] record_data;

	modport source (output valid, output req_type, output slot_index, output record_data,
		input ready);
	modport sink (input valid, input req_type, input slot_index, input record_data,
		output ready);
endinterface

interface frss_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [frss_pkg::STAT_W-1:0]  status;
	logic [frss_pkg::POS_W-1:0]   result_slot;
	logic [frss_pkg::DATA_W-1:0]  read_data;
	logic [frss_pkg::COUNT_W-1:0] live_count;

	modport source (output valid, output status, output result_slot, output read_data,
		output live_count, input ready);
	modport sink (input valid, input status, input result_slot, input read_data,
		input live_count, output ready);
endinterface

>>> rtl/frss_ctrl.sv
// Request sequencer of the fixed record slot store: accept, execute, hand off.
module frss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output frss_pkg::ctl_cmd_t cmd
);

	frss_pkg::ctl_state_t state_q, state_d;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frss_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			frss_pkg::CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = frss_pkg::CTL_EXEC;
				end
			end
			frss_pkg::CTL_EXEC: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = frss_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = frss_pkg::CTL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/frss_dpath.sv
// Datapath of the fixed record slot store: counters, free chain, memories, result register.
module frss_dpath #(
	parameter int SLOT_COUNT   = frss_pkg::SLOT_COUNT_DEF,
	parameter int RECORD_WIDTH = frss_pkg::RECORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frss_pkg::ctl_cmd_t            cmd,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic [frss_pkg::REQ_W-1:0]    req_type,
	input  logic [frss_pkg::POS_W-1:0]    slot_index,
	input  logic [frss_pkg::DATA_W-1:0]   record_data,
	output logic [frss_pkg::STAT_W-1:0]   status,
	output logic [frss_pkg::POS_W-1:0]    result_slot,
	output logic [frss_pkg::DATA_W-1:0]   read_data,
	output logic [frss_pkg::COUNT_W-1:0]  live_count
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W  = (CNT_W > frss_pkg::COUNT_W) ? CNT_W : frss_pkg::COUNT_W;
	// link word: {live, end, next}
	localparam int LINK_W = IDX_W + 2;
	localparam int L_LIVE = IDX_W + 1;
	localparam int L_END  = IDX_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

	logic [RECORD_WIDTH-1:0] rec_mem [SLOT_COUNT];
	logic [LINK_W-1:0]       link_mem [SLOT_COUNT];

	frss_pkg::delete_mode_t mode_q;
	logic [CNT_W-1:0]       live_q, used_q, removed_q;
	logic                   head_vld_q;
	logic [IDX_W-1:0]       head_q;

	frss_pkg::req_kind_t     req_q;
	logic [CMP_W-1:0]        pos_q;
	logic [RECORD_WIDTH-1:0] data_q;
	logic [RECORD_WIDTH-1:0] rec_rd_q;
	logic [LINK_W-1:0]       link_rd_q;

	logic [frss_pkg::STAT_W-1:0]  status_q;
	logic [frss_pkg::POS_W-1:0]   slot_q;
	logic [frss_pkg::DATA_W-1:0]  rdata_q;
	logic [frss_pkg::COUNT_W-1:0] count_q;

	// read address selection at accept
	logic [CMP_W-1:0] pos_in;
	logic [CNT_W-1:0] last_cnt;
	logic [IDX_W-1:0] rec_raddr, link_raddr;

	assign pos_in   = CMP_W'(slot_index);
	assign last_cnt = live_q - CNT_W'(1);

	always_comb begin
		rec_raddr  = pos_in[IDX_W-1:0];
		link_raddr = pos_in[IDX_W-1:0];
		if (mode_q == frss_pkg::MODE_MOVE_LAST && req_type == frss_pkg::REQ_DELETE) begin
			rec_raddr = last_cnt[IDX_W-1:0];
		end
		if (req_type == frss_pkg::REQ_ADD) begin
			link_raddr = head_q;
		end
	end

	// commit logic
	logic [CMP_W-1:0]        live_cmp, used_cmp;
	logic [IDX_W-1:0]        pos_idx;
	frss_pkg::status_t       st;
	logic [IDX_W-1:0]        slot;
	logic                    slot_hit;
	logic [RECORD_WIDTH-1:0] rdata;
	logic [CNT_W-1:0]        live_d, used_d, removed_d;
	logic                    head_vld_d;
	logic [IDX_W-1:0]        head_d;
	logic                    rec_we, link_we;
	logic [IDX_W-1:0]        rec_waddr, link_waddr;
	logic [RECORD_WIDTH-1:0] rec_wdata;
	logic [LINK_W-1:0]       link_wdata, live_link;
	logic [CMP_W-1:0]        slot_ext, live_ext;

	assign live_cmp  = CMP_W'(live_q);
	assign used_cmp  = CMP_W'(used_q);
	assign pos_idx   = pos_q[IDX_W-1:0];
	assign live_link = {1'b1, 1'b0, {IDX_W{1'b0}}};

	always_comb begin
		st         = frss_pkg::ST_OK;
		slot       = '0;
		slot_hit   = 1'b0;
		rdata      = '0;
		live_d     = live_q;
		used_d     = used_q;
		removed_d  = removed_q;
		head_vld_d = head_vld_q;
		head_d     = head_q;
		rec_we     = 1'b0;
		link_we    = 1'b0;
		rec_waddr  = '0;
		link_waddr = '0;
		rec_wdata  = data_q;
		link_wdata = live_link;
		case (req_q)
			frss_pkg::REQ_ADD: begin
				if (mode_q == frss_pkg::MODE_MOVE_LAST) begin
					if (live_q >= FULL_CNT) begin
						st = frss_pkg::ST_FULL;
					end else begin
						slot   = live_q[IDX_W-1:0];
						rec_we = 1'b1;
						if (removed_q != '0) begin
							removed_d = removed_q - CNT_W'(1);
						end else begin
							used_d = used_q + CNT_W'(1);
						end
						live_d = live_q + CNT_W'(1);
					end
				end else begin
					if (head_vld_q) begin
						slot       = head_q;
						head_vld_d = !link_rd_q[L_END];
						head_d     = link_rd_q[IDX_W-1:0];
					end else if (used_q < FULL_CNT) begin
						slot   = used_q[IDX_W-1:0];
						used_d = used_q + CNT_W'(1);
					end else begin
						st = frss_pkg::ST_FULL;
					end
					if (st == frss_pkg::ST_OK) begin
						rec_we  = 1'b1;
						link_we = 1'b1;
						live_d  = live_q + CNT_W'(1);
					end
				end
				rec_waddr  = slot;
				link_waddr = slot;
			end
			frss_pkg::REQ_READ: begin
				slot_hit = 1'b1;
				if (mode_q == frss_pkg::MODE_MOVE_LAST) begin
					if (pos_q >= live_cmp) begin
						st = frss_pkg::ST_BADPOS;
					end else begin
						rdata = rec_rd_q;
					end
				end else begin
					if (pos_q >= used_cmp) begin
						st = frss_pkg::ST_BADPOS;
					end else if (!link_rd_q[L_LIVE]) begin
						st = frss_pkg::ST_DELETED;
					end else begin
						rdata = rec_rd_q;
					end
				end
			end
			frss_pkg::REQ_DELETE: begin
				slot_hit = 1'b1;
				if (mode_q == frss_pkg::MODE_MOVE_LAST) begin
					if (pos_q >= live_cmp) begin
						st = frss_pkg::ST_BADPOS;
					end else begin
						// move the last live record into the hole
						rec_we    = 1'b1;
						rec_waddr = pos_idx;
						rec_wdata = rec_rd_q;
						removed_d = removed_q + CNT_W'(1);
						live_d    = live_q - CNT_W'(1);
					end
				end else begin
					if (pos_q >= used_cmp) begin
						st = frss_pkg::ST_BADPOS;
					end else if (!link_rd_q[L_LIVE]) begin
						st = frss_pkg::ST_DELETED;
					end else begin
						link_we    = 1'b1;
						link_waddr = pos_idx;
						link_wdata = head_vld_q ? {1'b0, 1'b0, head_q} : {1'b0, 1'b1, {IDX_W{1'b0}}};
						head_vld_d = 1'b1;
						head_d     = pos_idx;
						live_d     = live_q - CNT_W'(1);
					end
				end
			end
			frss_pkg::REQ_COUNT: begin
				st = frss_pkg::ST_OK;
			end
			default: begin
				st = frss_pkg::ST_OK;
			end
		endcase
	end

	assign slot_ext = CMP_W'(slot);
	assign live_ext = CMP_W'(live_d);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.commit && rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (cmd.accept) begin
			rec_rd_q <= rec_mem[rec_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (cmd.accept) begin
			link_rd_q <= link_mem[link_raddr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= frss_pkg::req_kind_t'(req_type);
			pos_q  <= pos_in;
			data_q <= record_data[RECORD_WIDTH-1:0];
		end
	end

	// store state; a mode change empties the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= frss_pkg::MODE_MOVE_LAST;
			live_q     <= '0;
			used_q     <= '0;
			removed_q  <= '0;
			head_vld_q <= 1'b0;
			head_q     <= '0;
		end else if (cfg_we) begin
			if (frss_pkg::delete_mode_t'(cfg_wdata) != mode_q) begin
				mode_q     <= frss_pkg::delete_mode_t'(cfg_wdata);
				live_q     <= '0;
				used_q     <= '0;
				removed_q  <= '0;
				head_vld_q <= 1'b0;
				head_q     <= '0;
			end
		end else if (cmd.commit) begin
			live_q     <= live_d;
			used_q     <= used_d;
			removed_q  <= removed_d;
			head_vld_q <= head_vld_d;
			head_q     <= head_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= st;
			slot_q   <= slot_hit ? pos_q[frss_pkg::POS_W-1:0] : slot_ext[frss_pkg::POS_W-1:0];
			rdata_q  <= frss_pkg::DATA_W'(rdata);
			count_q  <= live_ext[frss_pkg::COUNT_W-1:0];
		end
	end

	assign status      = status_q;
	assign result_slot = slot_q;
	assign read_data   = rdata_q;
	assign live_count  = count_q;

endmodule

>>> rtl/fixed_record_slot_store_unit.sv
// Top level of the fixed record slot store: controller, datapath and channel ports.
//
// Use: each transfer on req carries one request (add a record word, read a slot,
// delete a slot, or count live records). Each request produces exactly one
// transfer on rsp with a status, the slot concerned, read data and the live count
// after the request. cfg_we/cfg_wdata set the delete policy (0 move last record
// into the hole, 1 chain freed slots in a LIFO free list); writing a new value
// empties the store, writing the current value does nothing. Write it only while
// no request is in flight.
// Sequence: the accepting edge launches the registered reads of the record memory
// and the link memory; the commit edge checks bounds, commits the memory writes and
// counters and loads the response register. One request is in flight at a time:
// the store takes no new request until the last one has committed.
// Stall: req.ready returns high as soon as the response register is loaded, so the
// next request is accepted while the last response waits; if rsp is still held
// when the next request is ready to commit, hold it until the response transfers.
// Reset: arst_n clears the counters, the free chain and the policy (move last).
// Memory contents are not cleared; no response returns data from an unwritten slot.
module fixed_record_slot_store_unit #(
	parameter int SLOT_COUNT   = frss_pkg::SLOT_COUNT_DEF,
	parameter int RECORD_WIDTH = frss_pkg::RECORD_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	frss_req_if.sink   req,
	frss_rsp_if.source rsp
);

	frss_pkg::ctl_cmd_t cmd;

	// sequence accept, execute and response handoff
	frss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// hold store state, memories and the response register
	frss_dpath #(
		.SLOT_COUNT   (SLOT_COUNT),
		.RECORD_WIDTH (RECORD_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req.req_type),
		.slot_index  (req.slot_index),
		.record_data (req.record_data),
		.status      (rsp.status),
		.result_slot (rsp.result_slot),
		.read_data   (rsp.read_data),
		.live_count  (rsp.live_count)
	);

endmodule

>>> dv/tb_fixed_record_slot_store_unit.sv
// Self-checking testbench of the fixed record slot store: directed, fill and random requests.
module tb_fixed_record_slot_store_unit;

	localparam int SLOTS           = frss_pkg::SLOT_COUNT_DEF;
	localparam int TAG_LIVE        = -2;
	localparam int TAG_END         = -1;
	localparam int QUIET_LIMIT     = 3000;
	localparam int HOLD_OFF_CYCLES = 180;
	localparam int REPORT_LIMIT    = 10;
	localparam int PHASE_ITEMS     = 170;

	typedef logic [frss_pkg::POS_W-1:0] slot_idx_t;

	// One response as the store should produce it.
	typedef struct {
		frss_pkg::status_t            status;
		logic [frss_pkg::POS_W-1:0]   slot;
		logic [frss_pkg::DATA_W-1:0]  data;
		logic [frss_pkg::COUNT_W-1:0] live;
	} store_response_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	frss_req_if req_bus();
	frss_rsp_if rsp_bus();

	fixed_record_slot_store_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_bus),
		.rsp      (rsp_bus)
	);

	// Shadow copy of the store: policy, payloads, per-slot link tags and counters.
	// A link tag is TAG_LIVE for a live slot, TAG_END for the chain tail, or the
	// next free slot. free_head holds TAG_END when the chain is empty.
	frss_pkg::delete_mode_t      shadow_mode;
	logic [frss_pkg::DATA_W-1:0] shadow_records [SLOTS];
	int                          shadow_links [SLOTS];
	int                          free_head;
	int                          used_len;
	int                          hole_cnt;
	int                          live_cnt;

	store_response_t   awaited_responses [$];
	int                fail_count = 0;
	int                quiet_cycles = 0;
	int                hold_off_requests = 0;

	// Sender pacing: a burst runs for burst_left transfers, then a random gap if gaps_on.
	int                burst_left = 0;
	bit                gaps_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Empty the shadow store, as a reset or a change of policy does.
	function automatic void clear_shadow_store();
		for (int i = 0; i < SLOTS; i++) begin
			shadow_records[i] = '0;
			shadow_links[i]   = 0;
		end
		free_head = TAG_END;
		used_len  = 0;
		hole_cnt  = 0;
		live_cnt  = 0;
	endfunction

	// Apply one request to the shadow store and return the response it must give.
	function automatic store_response_t predict_store_request(frss_pkg::req_kind_t kind,
			logic [frss_pkg::POS_W-1:0] pos, logic [frss_pkg::DATA_W-1:0] data);
		store_response_t rsp_want;
		int              nxt;
		rsp_want.status = frss_pkg::ST_OK;
		rsp_want.slot   = '0;
		rsp_want.data   = '0;
		case (kind)
			frss_pkg::REQ_ADD: begin
				if (shadow_mode == frss_pkg::MODE_MOVE_LAST) begin
					// Write the first slot past the live region; reuse a hole before growing.
					if (live_cnt >= SLOTS) begin
						rsp_want.status = frss_pkg::ST_FULL;
					end else begin
						rsp_want.slot            = slot_idx_t'(live_cnt);
						shadow_records[live_cnt] = data;
						shadow_links[live_cnt]   = TAG_LIVE;
						if (hole_cnt > 0)
							hole_cnt--;
						else
							used_len++;
						live_cnt++;
					end
				end else begin
					// Pop the chain head, else append past the high-water mark.
					if (free_head != TAG_END) begin
						rsp_want.slot = slot_idx_t'(free_head);
						nxt           = shadow_links[free_head];
						shadow_records[free_head] = data;
						shadow_links[free_head]   = TAG_LIVE;
						free_head     = (nxt >= 0) ? nxt : TAG_END;
						live_cnt++;
					end else if (used_len < SLOTS) begin
						rsp_want.slot            = slot_idx_t'(used_len);
						shadow_records[used_len] = data;
						shadow_links[used_len]   = TAG_LIVE;
						used_len++;
						live_cnt++;
					end else begin
						rsp_want.status = frss_pkg::ST_FULL;
					end
				end
			end
			frss_pkg::REQ_READ: begin
				rsp_want.slot = pos;
				if (shadow_mode == frss_pkg::MODE_MOVE_LAST) begin
					if (pos >= live_cnt)
						rsp_want.status = frss_pkg::ST_BADPOS;
					else
						rsp_want.data = shadow_records[pos];
				end else begin
					if (pos >= used_len)
						rsp_want.status = frss_pkg::ST_BADPOS;
					else if (shadow_links[pos] != TAG_LIVE)
						rsp_want.status = frss_pkg::ST_DELETED;
					else
						rsp_want.data = shadow_records[pos];
				end
			end
			frss_pkg::REQ_DELETE: begin
				rsp_want.slot = pos;
				if (shadow_mode == frss_pkg::MODE_MOVE_LAST) begin
					// Move the last live record into the hole.
					if (pos >= live_cnt) begin
						rsp_want.status = frss_pkg::ST_BADPOS;
					end else begin
						shadow_records[pos] = shadow_records[live_cnt-1];
						hole_cnt++;
						live_cnt--;
					end
				end else begin
					// Push the slot onto the chain; refuse a slot that is already free.
					if (pos >= used_len) begin
						rsp_want.status = frss_pkg::ST_BADPOS;
					end else if (shadow_links[pos] != TAG_LIVE) begin
						rsp_want.status = frss_pkg::ST_DELETED;
					end else begin
						shadow_links[pos] = free_head;
						free_head         = pos;
						live_cnt--;
					end
				end
			end
			default: ;
		endcase
		rsp_want.live = live_cnt[frss_pkg::COUNT_W-1:0];
		return rsp_want;
	endfunction

	function automatic bit shadow_store_full();
		if (shadow_mode == frss_pkg::MODE_MOVE_LAST)
			return live_cnt >= SLOTS;
		return free_head == TAG_END && used_len >= SLOTS;
	endfunction

	function automatic logic [frss_pkg::DATA_W-1:0] random_word();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// Offer one request, hold it until the transfer, then record what it must return.
	// valid stays high across a burst and drops only for a gap.
	task automatic send_request(frss_pkg::req_kind_t kind, logic [frss_pkg::POS_W-1:0] pos,
			logic [frss_pkg::DATA_W-1:0] data);
		store_response_t want;
		if (burst_left == 0) begin
			if (gaps_on) begin
				req_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 14);
		end
		burst_left--;
		req_bus.valid       <= 1'b1;
		req_bus.req_type    <= kind;
		req_bus.slot_index  <= pos;
		req_bus.record_data <= data;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		want = predict_store_request(kind, pos, data);
		awaited_responses.insert(awaited_responses.size(), want);
	endtask

	// Drop valid and wait until every response has come back.
	task automatic settle_store();
		req_bus.valid <= 1'b0;
		burst_left = 0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the policy register while the store is idle; a new value empties it.
	task automatic write_delete_mode(frss_pkg::delete_mode_t mode);
		settle_store();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (mode != shadow_mode) begin
			shadow_mode = mode;
			clear_shadow_store();
		end
	endtask

	// Pick a request with the given share of adds; aim most positions inside the live
	// (move last) or used (free list) region, some at its edge and some anywhere.
	task automatic issue_random_request(int add_pct);
		int                  pick;
		int                  limit;
		frss_pkg::req_kind_t kind;
		slot_idx_t           pos;
		pick = $urandom_range(0, 99);
		if (pick < add_pct) begin
			kind = frss_pkg::REQ_ADD;
		end else begin
			pick = $urandom_range(0, 99);
			kind = (pick < 45) ? frss_pkg::REQ_READ :
				(pick < 85) ? frss_pkg::REQ_DELETE : frss_pkg::REQ_COUNT;
		end
		limit = (shadow_mode == frss_pkg::MODE_MOVE_LAST) ? live_cnt : used_len;
		pick  = $urandom_range(0, 9);
		if (pick < 7 && limit > 0)
			pos = slot_idx_t'($urandom_range(0, limit - 1));
		else if (pick == 7 && limit < SLOTS)
			pos = slot_idx_t'(limit);
		else
			pos = slot_idx_t'($urandom_range(0, SLOTS - 1));
		send_request(kind, pos, random_word());
	endtask

	// Requests on the store straight out of reset.
	task automatic test_empty_store();
		send_request(frss_pkg::REQ_COUNT, 8'd0, random_word());
		send_request(frss_pkg::REQ_READ, 8'd255, random_word());
		send_request(frss_pkg::REQ_DELETE, 8'd0, random_word());
	endtask

	task automatic test_move_last_basics();
		send_request(frss_pkg::REQ_ADD, 8'd0, '1);
		send_request(frss_pkg::REQ_ADD, 8'd255, '0);
		send_request(frss_pkg::REQ_ADD, 8'd7, 64'hA5A5_5A5A_0123_4567);
		send_request(frss_pkg::REQ_READ, 8'd0, '0);
		send_request(frss_pkg::REQ_READ, 8'd2, '0);
		send_request(frss_pkg::REQ_READ, 8'd3, '0);
		// Delete inside the region: the last record fills the hole.
		send_request(frss_pkg::REQ_DELETE, 8'd0, '0);
		send_request(frss_pkg::REQ_READ, 8'd0, '0);
		// Delete the last record itself.
		send_request(frss_pkg::REQ_DELETE, 8'd1, '0);
		send_request(frss_pkg::REQ_ADD, 8'd0, 64'h0F0F_F0F0_8000_0001);
		send_request(frss_pkg::REQ_COUNT, 8'd255, '1);
	endtask

	task automatic test_free_list_basics();
		write_delete_mode(frss_pkg::MODE_FREE_LIST);
		for (int i = 0; i < 4; i++)
			send_request(frss_pkg::REQ_ADD, 8'd0, random_word());
		send_request(frss_pkg::REQ_DELETE, 8'd1, '0);
		send_request(frss_pkg::REQ_READ, 8'd1, '0);
		// Second delete of the same slot is refused.
		send_request(frss_pkg::REQ_DELETE, 8'd1, '0);
		send_request(frss_pkg::REQ_READ, 8'd4, '0);
		send_request(frss_pkg::REQ_DELETE, 8'd3, '0);
		// Chain is LIFO: slot 3 comes back first, then 1, then append at 4.
		send_request(frss_pkg::REQ_ADD, 8'd0, random_word());
		send_request(frss_pkg::REQ_ADD, 8'd0, random_word());
		send_request(frss_pkg::REQ_ADD, 8'd0, random_word());
		// Rewriting the current policy must leave the store as it is.
		write_delete_mode(frss_pkg::MODE_FREE_LIST);
		send_request(frss_pkg::REQ_COUNT, 8'd0, '0);
	endtask

	// Fill every slot, push past full, punch holes and fill again.
	task automatic test_fill_to_full(frss_pkg::delete_mode_t mode);
		write_delete_mode(mode == frss_pkg::MODE_MOVE_LAST ?
			frss_pkg::MODE_FREE_LIST : frss_pkg::MODE_MOVE_LAST);
		write_delete_mode(mode);
		while (!shadow_store_full())
			send_request(frss_pkg::REQ_ADD, slot_idx_t'($urandom_range(0, SLOTS - 1)),
				random_word());
		repeat (3) send_request(frss_pkg::REQ_ADD, slot_idx_t'($urandom_range(0, SLOTS - 1)),
			random_word());
		send_request(frss_pkg::REQ_READ, 8'd255, '0);
		send_request(frss_pkg::REQ_READ, 8'd0, '0);
		send_request(frss_pkg::REQ_DELETE, 8'd255, '0);
		repeat (8) send_request(frss_pkg::REQ_DELETE,
			slot_idx_t'($urandom_range(0, SLOTS - 1)), '0);
		repeat (4) send_request(frss_pkg::REQ_READ,
			slot_idx_t'($urandom_range(0, SLOTS - 1)), '0);
		while (!shadow_store_full())
			send_request(frss_pkg::REQ_ADD, slot_idx_t'($urandom_range(0, SLOTS - 1)),
				random_word());
		send_request(frss_pkg::REQ_ADD, 8'd0, random_word());
	endtask

	// Random phases alternating the policy, each with its own add share and pacing.
	task automatic test_random_mix();
		int add_pct;
		for (int ph = 0; ph < 6; ph++) begin
			write_delete_mode(ph % 2 == 1 ? frss_pkg::MODE_FREE_LIST : frss_pkg::MODE_MOVE_LAST);
			add_pct = $urandom_range(25, 65);
			gaps_on = (ph != 2 && ph != 5);
			repeat (PHASE_ITEMS) issue_random_request(add_pct);
		end
		gaps_on = 1'b1;
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		write_delete_mode(frss_pkg::MODE_MOVE_LAST);
		gaps_on = 1'b0;
		hold_off_requests <= hold_off_requests + 1;
		repeat (60) issue_random_request(50);
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= 1'b0;
		req_bus.valid       <= 1'b0;
		req_bus.req_type    <= frss_pkg::REQ_COUNT;
		req_bus.slot_index  <= '0;
		req_bus.record_data <= '0;
		shadow_mode = frss_pkg::MODE_MOVE_LAST;
		clear_shadow_store();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_move_last_basics();
		test_free_list_basics();
		test_fill_to_full(frss_pkg::MODE_MOVE_LAST);
		test_fill_to_full(frss_pkg::MODE_FREE_LIST);
		test_random_mix();
		test_backpressure();
		write_delete_mode(frss_pkg::MODE_FREE_LIST);
		repeat (40) issue_random_request(50);

		settle_store();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && awaited_responses.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Receiver: rotate a stall pattern, swap in a fresh one each time pattern_age wraps
	// (sometimes all ready), and serve long hold-off requests.
	initial begin
		logic [15:0] ready_pattern;
		int          pattern_age;
		int          hold_left;
		int          hold_off_served;
		ready_pattern   = 16'hFFFF;
		pattern_age     = 0;
		hold_left       = 0;
		hold_off_served = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_bus.ready <= 1'b0;
			end else if (hold_off_requests != hold_off_served) begin
				hold_off_served = hold_off_requests;
				hold_left       = HOLD_OFF_CYCLES;
				rsp_bus.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
				pattern_age++;
				if (pattern_age == 48) begin
					pattern_age = 0;
					case ($urandom_range(0, 3))
						0:       ready_pattern = 16'hFFFF;
						1:       ready_pattern = 16'($urandom) | 16'h8000;
						2:       ready_pattern = 16'($urandom & $urandom) | 16'h8000;
						default: ready_pattern = 16'($urandom | $urandom);
					endcase
				end
			end
		end
	end

	// Compare each response transfer with the oldest outstanding prediction.
	always @(posedge clk) begin : check_responses
		store_response_t want;
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (awaited_responses.size() == 0) begin
				note_failure($sformatf(
					"unexpected response: status=%0d slot=%0d data=%h live=%0d",
					rsp_bus.status, rsp_bus.result_slot, rsp_bus.read_data,
					rsp_bus.live_count));
			end else begin
				want = awaited_responses.pop_front();
				if (rsp_bus.status !== want.status || rsp_bus.result_slot !== want.slot ||
						rsp_bus.read_data !== want.data || rsp_bus.live_count !== want.live)
					note_failure({
						$sformatf("mismatch: expected status=%0d slot=%0d data=%h live=%0d,",
							want.status, want.slot, want.data, want.live),
						$sformatf(" got status=%0d slot=%0d data=%h live=%0d",
							rsp_bus.status, rsp_bus.result_slot, rsp_bus.read_data,
							rsp_bus.live_count)});
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
				(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

>>> files.f
rtl/frss_pkg.sv
rtl/frss_if.sv
rtl/frss_ctrl.sv
rtl/frss_dpath.sv
rtl/fixed_record_slot_store_unit.sv
dv/tb_fixed_record_slot_store_unit.sv
